// ===== src/wiper_sweep_sequencer_defines.svh =====
// assertion helpers for the wiper sweep sequencer
`ifndef WIPER_SWEEP_SEQUENCER_DEFINES_SVH
`define WIPER_SWEEP_SEQUENCER_DEFINES_SVH

// clocked check, off while reset is asserted
`define WSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds through reset
`define WSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/wss_pkg.sv =====
package wss_pkg;

  localparam int unsigned KnobW   = 12;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DutyW   = 12;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned ThreshW = 13;
  localparam int unsigned DurW    = 16;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned RegDatW = 16;

  localparam logic [ModeW-1:0] MODE_PARKED = 2'd0;
  localparam logic [ModeW-1:0] MODE_PULSE  = 2'd1;
  localparam logic [ModeW-1:0] MODE_SLOW   = 2'd2;
  localparam logic [ModeW-1:0] MODE_FAST   = 2'd3;

  localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
  localparam logic [PhaseW-1:0] PH_UP   = 2'd1;
  localparam logic [PhaseW-1:0] PH_DOWN = 2'd2;

  localparam logic [DutyW-1:0] DUTY_REST = 12'd800;
  localparam logic [DutyW-1:0] DUTY_FULL = 12'd3300;

  localparam logic [RegIdxW-1:0] REG_CONTROL_SOURCE  = 4'd0;
  localparam logic [RegIdxW-1:0] REG_THRESH_OFF_INT  = 4'd1;
  localparam logic [RegIdxW-1:0] REG_THRESH_INT_LOW  = 4'd2;
  localparam logic [RegIdxW-1:0] REG_THRESH_LOW_HIGH = 4'd3;
  localparam logic [RegIdxW-1:0] REG_DUR_INT         = 4'd4;
  localparam logic [RegIdxW-1:0] REG_DUR_LOW         = 4'd5;
  localparam logic [RegIdxW-1:0] REG_DUR_HIGH        = 4'd6;
  localparam logic [RegIdxW-1:0] REG_INT_PAUSE       = 4'd7;

  localparam logic [ThreshW-1:0] RST_THRESH_OFF_INT  = 13'd500;
  localparam logic [ThreshW-1:0] RST_THRESH_INT_LOW  = 13'd2000;
  localparam logic [ThreshW-1:0] RST_THRESH_LOW_HIGH = 13'd3500;
  localparam logic [DurW-1:0]    RST_DUR_INT         = 16'd500;
  localparam logic [DurW-1:0]    RST_DUR_LOW         = 16'd800;
  localparam logic [DurW-1:0]    RST_DUR_HIGH        = 16'd300;
  localparam logic [DurW-1:0]    RST_INT_PAUSE       = 16'd3000;

  typedef struct packed {
    logic               control_source;
    logic [ThreshW-1:0] thresh_off_int;
    logic [ThreshW-1:0] thresh_int_low;
    logic [ThreshW-1:0] thresh_low_high;
    logic [DurW-1:0]    dur_int;
    logic [DurW-1:0]    dur_low;
    logic [DurW-1:0]    dur_high;
    logic [DurW-1:0]    int_pause;
  } cfg_t;

  typedef struct packed {
    logic [KnobW-1:0] knob_sample;
    logic [ModeW-1:0] pc_mode;
    logic [TimeW-1:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic              duty_write;
    logic [DutyW-1:0]  duty_value;
    logic [ModeW-1:0]  mode_now;
    logic [PhaseW-1:0] phase_now;
  } result_t;

endpackage

// ===== src/wss_if.sv =====
interface wss_in_if;
  logic                        valid;
  logic                        ready;
  logic [wss_pkg::KnobW-1:0]   knob_sample;
  logic [wss_pkg::ModeW-1:0]   pc_mode;
  logic [wss_pkg::TimeW-1:0]   now_ms;

  modport source (output valid, knob_sample, pc_mode, now_ms, input ready);
  modport sink (input valid, knob_sample, pc_mode, now_ms, output ready);
endinterface

interface wss_out_if;
  logic                        valid;
  logic                        ready;
  logic                        duty_write;
  logic [wss_pkg::DutyW-1:0]   duty_value;
  logic [wss_pkg::ModeW-1:0]   mode_now;
  logic [wss_pkg::PhaseW-1:0]  phase_now;

  modport source (output valid, duty_write, duty_value, mode_now, phase_now, input ready);
  modport sink (input valid, duty_write, duty_value, mode_now, phase_now, output ready);
endinterface

interface wss_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wss_pkg::RegIdxW-1:0]   reg_index;
  logic [wss_pkg::RegDatW-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== src/wss_cfg_regs.sv =====
module wss_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [wss_pkg::RegIdxW-1:0]   wr_index_i,
  input  logic [wss_pkg::RegDatW-1:0]   wr_data_i,
  output wss_pkg::cfg_t                 cfg_o
);

  wss_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        wss_pkg::REG_CONTROL_SOURCE:  cfg_d.control_source  = wr_data_i[0];
        wss_pkg::REG_THRESH_OFF_INT:  cfg_d.thresh_off_int  = wr_data_i[wss_pkg::ThreshW-1:0];
        wss_pkg::REG_THRESH_INT_LOW:  cfg_d.thresh_int_low  = wr_data_i[wss_pkg::ThreshW-1:0];
        wss_pkg::REG_THRESH_LOW_HIGH: cfg_d.thresh_low_high = wr_data_i[wss_pkg::ThreshW-1:0];
        wss_pkg::REG_DUR_INT:         cfg_d.dur_int         = wr_data_i;
        wss_pkg::REG_DUR_LOW:         cfg_d.dur_low         = wr_data_i;
        wss_pkg::REG_DUR_HIGH:        cfg_d.dur_high        = wr_data_i;
        wss_pkg::REG_INT_PAUSE:       cfg_d.int_pause       = wr_data_i;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_source  <= 1'b0;
      cfg_q.thresh_off_int  <= wss_pkg::RST_THRESH_OFF_INT;
      cfg_q.thresh_int_low  <= wss_pkg::RST_THRESH_INT_LOW;
      cfg_q.thresh_low_high <= wss_pkg::RST_THRESH_LOW_HIGH;
      cfg_q.dur_int         <= wss_pkg::RST_DUR_INT;
      cfg_q.dur_low         <= wss_pkg::RST_DUR_LOW;
      cfg_q.dur_high        <= wss_pkg::RST_DUR_HIGH;
      cfg_q.int_pause       <= wss_pkg::RST_INT_PAUSE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/wss_mode_sel.sv =====
module wss_mode_sel (
  input  wss_pkg::cfg_t               cfg_i,
  input  logic [wss_pkg::KnobW-1:0]   knob_sample_i,
  input  logic [wss_pkg::ModeW-1:0]   pc_mode_i,
  output logic [wss_pkg::ModeW-1:0]   mode_o
);

  logic [wss_pkg::ThreshW-1:0] knob_ext;

  assign knob_ext = {1'b0, knob_sample_i};

  // thresholds tested in fixed order, whatever their values
  always_comb begin
    if (cfg_i.control_source) begin
      mode_o = pc_mode_i;
    end else if (knob_ext < cfg_i.thresh_off_int) begin
      mode_o = wss_pkg::MODE_PARKED;
    end else if (knob_ext < cfg_i.thresh_int_low) begin
      mode_o = wss_pkg::MODE_PULSE;
    end else if (knob_ext < cfg_i.thresh_low_high) begin
      mode_o = wss_pkg::MODE_SLOW;
    end else begin
      mode_o = wss_pkg::MODE_FAST;
    end
  end

endmodule

// ===== src/wss_sweep.sv =====
module wss_sweep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  wss_pkg::cfg_t                cfg_i,
  input  logic [wss_pkg::ModeW-1:0]    mode_i,
  input  logic [wss_pkg::TimeW-1:0]    now_ms_i,
  output wss_pkg::result_t             result_o
);

  logic [wss_pkg::PhaseW-1:0] phase_d, phase_q;
  logic [wss_pkg::TimeW-1:0]  start_d, start_q;
  logic [wss_pkg::DurW-1:0]   dur;
  logic [wss_pkg::DurW:0]     target;
  logic [wss_pkg::TimeW-1:0]  elapsed;

  always_comb begin
    case (mode_i)
      wss_pkg::MODE_PULSE: dur = cfg_i.dur_int;
      wss_pkg::MODE_SLOW:  dur = cfg_i.dur_low;
      default:             dur = cfg_i.dur_high;
    endcase
  end

  // return stroke target, one bit wider so the pause cannot overflow
  assign target  = {1'b0, dur} + ((mode_i == wss_pkg::MODE_PULSE) ? {1'b0, cfg_i.int_pause}
                                                                  : '0);
  // wrapping difference
  assign elapsed = now_ms_i - start_q;

  always_comb begin
    phase_d             = phase_q;
    start_d             = start_q;
    result_o.duty_write = 1'b0;
    result_o.duty_value = '0;
    result_o.mode_now   = mode_i;
    if (mode_i == wss_pkg::MODE_PARKED) begin
      phase_d             = wss_pkg::PH_IDLE;
      result_o.duty_write = 1'b1;
      result_o.duty_value = wss_pkg::DUTY_REST;
    end else begin
      unique case (phase_q)
        wss_pkg::PH_UP: begin
          if (elapsed >= {{(wss_pkg::TimeW-wss_pkg::DurW){1'b0}}, dur}) begin
            phase_d             = wss_pkg::PH_DOWN;
            start_d             = now_ms_i;
            result_o.duty_write = 1'b1;
            result_o.duty_value = wss_pkg::DUTY_REST;
          end
        end
        wss_pkg::PH_DOWN: begin
          if (elapsed >= {{(wss_pkg::TimeW-wss_pkg::DurW-1){1'b0}}, target}) begin
            phase_d = wss_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d             = wss_pkg::PH_UP;
          start_d             = now_ms_i;
          result_o.duty_write = 1'b1;
          result_o.duty_value = wss_pkg::DUTY_FULL;
        end
      endcase
    end
    result_o.phase_now = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wss_pkg::PH_IDLE;
      start_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      start_q <= start_d;
    end
  end

endmodule

// ===== src/wiper_sweep_sequencer.sv =====
// path: each poll is registered in the poll register, then in the result register
// throughput: one poll per cycle unless result ready stalls; the sweep state updates
// in the same cycle as the result register loads, so the next poll sees it at once
// reset: asynchronous active low, clears the sweep to idle with start time zero,
// loads register defaults and empties both pipeline registers
`include "wiper_sweep_sequencer_defines.svh"

module wiper_sweep_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  wss_cfg_if.sink        cfg_i,
  wss_in_if.sink         poll_i,
  wss_out_if.source      result_o
);

  wss_pkg::cfg_t              cfg;
  wss_pkg::poll_t             poll_q;
  wss_pkg::result_t           res_d, res_q;
  logic                       poll_valid_q;
  logic                       res_valid_q;
  logic                       advance;
  logic                       poll_fire;
  logic [wss_pkg::ModeW-1:0]  mode;

  assign cfg_i.ready = 1'b1;

  wss_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.reg_index),
    .wr_data_i  (cfg_i.wdata),
    .cfg_o      (cfg)
  );

  // poll register moves on whenever the result register is free or drains
  assign advance      = poll_valid_q && (!res_valid_q || result_o.ready);
  assign poll_i.ready = !poll_valid_q || advance;
  assign poll_fire    = poll_i.valid && poll_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      poll_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_fire) begin
      poll_q.knob_sample <= poll_i.knob_sample;
      poll_q.pc_mode     <= poll_i.pc_mode;
      poll_q.now_ms      <= poll_i.now_ms;
    end
  end

  wss_mode_sel u_mode_sel (
    .cfg_i         (cfg),
    .knob_sample_i (poll_q.knob_sample),
    .pc_mode_i     (poll_q.pc_mode),
    .mode_o        (mode)
  );

  wss_sweep u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .cfg_i    (cfg),
    .mode_i   (mode),
    .now_ms_i (poll_q.now_ms),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.duty_write = res_q.duty_write;
  assign result_o.duty_value = res_q.duty_value;
  assign result_o.mode_now   = res_q.mode_now;
  assign result_o.phase_now  = res_q.phase_now;

  `WSS_ASSERT(a_poll_held, clk_i, rst_ni, poll_fire |=> poll_valid_q, "accepted poll lost")
  `WSS_ASSERT(a_off_rest, clk_i, rst_ni,
      (res_valid_q && res_q.mode_now == wss_pkg::MODE_PARKED) |->
      (res_q.duty_write && res_q.duty_value == wss_pkg::DUTY_REST &&
       res_q.phase_now == wss_pkg::PH_IDLE),
      "off mode result not at rest")
  `WSS_ASSERT(a_no_write_zero, clk_i, rst_ni,
      (res_valid_q && !res_q.duty_write) |-> (res_q.duty_value == '0),
      "duty value without write")
  `WSS_ASSERT(a_up_full, clk_i, rst_ni,
      (res_valid_q && res_q.duty_write && res_q.phase_now == wss_pkg::PH_UP) |->
      (res_q.duty_value == wss_pkg::DUTY_FULL),
      "up stroke without full duty")
  `WSS_ASSERT_ALWAYS(a_reset_empty, clk_i,
      !rst_ni |-> (!res_valid_q && !poll_valid_q),
      "pipeline not empty in reset")

endmodule
